### src/eipv4rx_pkg.sv
// ----------------------------------------------------------------------------
// eipv4rx_pkg
// Shared types, constants and field helpers for the Ethernet/IPv4 receive
// header classifier.
// ----------------------------------------------------------------------------
package eipv4rx_pkg;

	localparam int DEFAULT_MAX_FRAME_BYTES = 2048;

	// width of byte positions and length sums (covers 14 + 65535 and 74 + 65535)
	localparam int CMP_W = 17;
	typedef logic [CMP_W-1:0] pos_t;

	localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam pos_t POS_ETYPE      = pos_t'(12);
	localparam pos_t POS_IHL        = pos_t'(14);
	localparam pos_t POS_TLEN       = pos_t'(16);
	localparam pos_t POS_PROTO      = pos_t'(23);
	localparam pos_t POS_SRC_ADDR   = pos_t'(26);
	localparam pos_t POS_DST_ADDR   = pos_t'(30);
	localparam pos_t ETH_HDR_LEN    = pos_t'(14);
	localparam pos_t IPV4_MIN_FRAME = pos_t'(34);
	localparam pos_t IPV4_MIN_IHL   = pos_t'(20);
	localparam pos_t UDP_HDR_LEN    = pos_t'(8);
	localparam pos_t UDP_DST_PORT   = pos_t'(2);
	localparam pos_t UDP_LEN_FIELD  = pos_t'(4);
	localparam pos_t FRAME_LEN_OUT_MAX = pos_t'(2047);

	typedef enum logic [2:0] {
		CLS_SHORT    = 3'd0,
		CLS_ARP      = 3'd1,
		CLS_ICMP_OK  = 3'd2,
		CLS_ICMP_BAD = 3'd3,
		CLS_TCP      = 3'd4,
		CLS_UDP_OK   = 3'd5,
		CLS_UDP_BAD  = 3'd6,
		CLS_OTHER    = 3'd7
	} class_t;

	typedef struct packed {
		logic [15:0] ether_kind;
		logic [3:0]  header_words;
		logic [15:0] ip_total_length;
		logic [7:0]  ip_protocol;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] udp_sport;
		logic [15:0] udp_dport;
		logic [15:0] udp_length;
	} hdr_t;

	typedef struct packed {
		class_t      frame_class;
		logic [10:0] frame_length;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [10:0] payload_offset;
		logic [15:0] payload_length;
	} result_t;

	function automatic logic [15:0] put16(logic [15:0] r, pos_t pos, pos_t base,
			logic [7:0] b);
		logic [15:0] v;
		v = r;
		if (pos == base) begin
			v[15:8] = b;
		end else if (pos == base + pos_t'(1)) begin
			v[7:0] = b;
		end
		return v;
	endfunction

	function automatic logic [31:0] put32(logic [31:0] r, pos_t pos, pos_t base,
			logic [7:0] b);
		logic [31:0] v;
		v = r;
		if (pos == base) begin
			v[31:24] = b;
		end else if (pos == base + pos_t'(1)) begin
			v[23:16] = b;
		end else if (pos == base + pos_t'(2)) begin
			v[15:8] = b;
		end else if (pos == base + pos_t'(3)) begin
			v[7:0] = b;
		end
		return v;
	endfunction

endpackage

### src/eipv4rx_byte_if.sv
// ----------------------------------------------------------------------------
// eipv4rx_byte_if
// Receive byte channel: one frame byte per request, with a last-byte mark.
// ----------------------------------------------------------------------------
interface eipv4rx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       last_byte;

	modport source(output valid, output frame_byte, output last_byte, input ready);
	modport sink(input valid, input frame_byte, input last_byte, output ready);
endinterface

### src/eipv4rx_class_if.sv
// ----------------------------------------------------------------------------
// eipv4rx_class_if
// Classification channel: one request per received frame.
// ----------------------------------------------------------------------------
interface eipv4rx_class_if;
	logic        valid;
	logic        ready;
	logic [2:0]  frame_class;
	logic [10:0] frame_length;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [10:0] payload_offset;
	logic [15:0] payload_length;

	modport source(output valid, output frame_class, output frame_length,
		output source_address, output dest_address, output source_port,
		output dest_port, output payload_offset, output payload_length, input ready);
	modport sink(input valid, input frame_class, input frame_length,
		input source_address, input dest_address, input source_port,
		input dest_port, input payload_offset, input payload_length, output ready);
endinterface

### src/eipv4rx_capture.sv
// ----------------------------------------------------------------------------
// eipv4rx_capture
// Input register, byte counter and header field capture. At the last byte the
// completed fields are handed to a snapshot register and the state clears.
// ----------------------------------------------------------------------------
module eipv4rx_capture
	import eipv4rx_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES,
	localparam int CW = $clog2(MAX_FRAME_BYTES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	eipv4rx_byte_if.sink         rx,
	input  logic                 down_ready,
	output logic                 valid_s2,
	output hdr_t                 hdr_s2,
	output logic [CW-1:0]        len_s2
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          last_s1;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_n;
	hdr_t          hdr_q;
	hdr_t          hdr_n;
	pos_t          pos;
	pos_t          udp_off;
	logic          cnt_ok;
	logic          s2_free;
	logic          take;

	assign s2_free  = !valid_s2 || down_ready;
	assign take     = valid_s1 && (!last_s1 || s2_free);
	assign rx.ready = !valid_s1 || take;

	assign pos    = CMP_W'(count_q);
	assign cnt_ok = count_q < CW'(MAX_FRAME_BYTES);

	always_comb begin
		hdr_n   = hdr_q;
		udp_off = ETH_HDR_LEN + pos_t'({hdr_q.header_words, 2'b00});
		count_n = count_q;
		if (cnt_ok) begin
			hdr_n.ether_kind = put16(hdr_q.ether_kind, pos, POS_ETYPE, byte_s1);
			if (pos == POS_IHL) begin
				hdr_n.header_words = byte_s1[3:0];
			end
			hdr_n.ip_total_length = put16(hdr_q.ip_total_length, pos, POS_TLEN, byte_s1);
			if (pos == POS_PROTO) begin
				hdr_n.ip_protocol = byte_s1;
			end
			hdr_n.src_addr = put32(hdr_q.src_addr, pos, POS_SRC_ADDR, byte_s1);
			hdr_n.dst_addr = put32(hdr_q.dst_addr, pos, POS_DST_ADDR, byte_s1);
			udp_off = ETH_HDR_LEN + pos_t'({hdr_n.header_words, 2'b00});
			hdr_n.udp_sport = put16(hdr_q.udp_sport, pos, udp_off, byte_s1);
			hdr_n.udp_dport = put16(hdr_q.udp_dport, pos, udp_off + UDP_DST_PORT, byte_s1);
			hdr_n.udp_length = put16(hdr_q.udp_length, pos, udp_off + UDP_LEN_FIELD,
				byte_s1);
			count_n = count_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.frame_byte;
			last_s1 <= rx.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			hdr_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				if (last_s1) begin
					count_q <= '0;
					hdr_q   <= '0;
				end else begin
					count_q <= count_n;
					hdr_q   <= hdr_n;
				end
			end
			if (take && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (down_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_s1) begin
			hdr_s2 <= hdr_n;
			len_s2 <= count_n;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_FRAME_BYTES))
		else $error("byte count beyond frame store size");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last_s1) |=> (count_q == '0 && valid_s2))
		else $error("state not cleared or snapshot not loaded after last byte");

	a_snapshot_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !down_ready) |=> (valid_s2 && $stable(len_s2) && $stable(hdr_s2)))
		else $error("pending snapshot lost while downstream stalled");

endmodule

### src/eipv4rx_classify.sv
// ----------------------------------------------------------------------------
// eipv4rx_classify
// Frame classification and length checks on the captured header snapshot,
// with the result register that drives the classification channel.
// ----------------------------------------------------------------------------
module eipv4rx_classify
	import eipv4rx_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES,
	localparam int CW = $clog2(MAX_FRAME_BYTES + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s2,
	input  hdr_t            hdr_s2,
	input  logic [CW-1:0]   len_s2,
	output logic            up_ready,
	eipv4rx_class_if.source result
);

	result_t res_n;
	result_t res_q;
	logic    valid_q;
	pos_t    len_w;
	pos_t    ihl;
	pos_t    tl;
	pos_t    ul;
	pos_t    udp_off;
	logic    ip_ok;
	logic    udp_ok;

	assign up_ready = !valid_q || result.ready;

	assign len_w   = CMP_W'(len_s2);
	assign ihl     = pos_t'({hdr_s2.header_words, 2'b00});
	assign tl      = pos_t'(hdr_s2.ip_total_length);
	assign ul      = pos_t'(hdr_s2.udp_length);
	assign udp_off = ETH_HDR_LEN + ihl;
	assign ip_ok   = (ihl >= IPV4_MIN_IHL) && (tl >= ihl + UDP_HDR_LEN)
		&& (ETH_HDR_LEN + tl <= len_w);
	assign udp_ok  = ip_ok && (ul >= UDP_HDR_LEN) && (udp_off + ul <= len_w);

	always_comb begin
		res_n = '0;
		res_n.frame_length = (len_w > FRAME_LEN_OUT_MAX) ? 11'(FRAME_LEN_OUT_MAX)
			: 11'(len_w);
		priority if (len_w < ETH_HDR_LEN) begin
			res_n.frame_class = CLS_SHORT;
		end else if (hdr_s2.ether_kind == ETH_TYPE_ARP) begin
			res_n.frame_class = CLS_ARP;
		end else if (hdr_s2.ether_kind == ETH_TYPE_IPV4 && len_w >= IPV4_MIN_FRAME) begin
			priority if (hdr_s2.ip_protocol == PROTO_ICMP) begin
				res_n.frame_class = ip_ok ? CLS_ICMP_OK : CLS_ICMP_BAD;
				if (ip_ok) begin
					res_n.payload_offset = 11'(ETH_HDR_LEN);
					res_n.payload_length = hdr_s2.ip_total_length;
				end
			end else if (hdr_s2.ip_protocol == PROTO_TCP) begin
				res_n.frame_class = CLS_TCP;
			end else if (hdr_s2.ip_protocol == PROTO_UDP) begin
				res_n.frame_class = udp_ok ? CLS_UDP_OK : CLS_UDP_BAD;
				if (udp_ok) begin
					res_n.source_port    = hdr_s2.udp_sport;
					res_n.dest_port      = hdr_s2.udp_dport;
					res_n.payload_offset = 11'(udp_off + UDP_HDR_LEN);
					res_n.payload_length = 16'(ul - UDP_HDR_LEN);
				end
			end else begin
				res_n.frame_class = CLS_OTHER;
			end
			if (res_n.frame_class != CLS_OTHER) begin
				res_n.source_address = hdr_s2.src_addr;
				res_n.dest_address   = hdr_s2.dst_addr;
			end
		end else begin
			res_n.frame_class = CLS_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && up_ready) begin
			res_q <= res_n;
		end
	end

	assign result.valid          = valid_q;
	assign result.frame_class    = res_q.frame_class;
	assign result.frame_length   = res_q.frame_length;
	assign result.source_address = res_q.source_address;
	assign result.dest_address   = res_q.dest_address;
	assign result.source_port    = res_q.source_port;
	assign result.dest_port      = res_q.dest_port;
	assign result.payload_offset = res_q.payload_offset;
	assign result.payload_length = res_q.payload_length;

	a_short_len: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.frame_class == CLS_SHORT) |-> (res_q.frame_length < 11'(ETH_HDR_LEN)))
		else $error("short class on a frame of header length or more");

	a_udp_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && res_q.frame_class == CLS_UDP_OK)
		|-> (res_q.payload_offset >= 11'(ETH_HDR_LEN + IPV4_MIN_IHL + UDP_HDR_LEN)))
		else $error("udp payload offset inside the headers");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result.ready) |=> (valid_q && $stable(res_q)))
		else $error("result changed while the receiver stalled");

endmodule

### src/ethernet_ipv4_rx_classifier_core.sv
// ----------------------------------------------------------------------------
// ethernet_ipv4_rx_classifier_core
// Ethernet/IPv4 receive header classifier.
//
// rx carries one frame byte per request, in wire order, last_byte set on the
// final byte. For each frame one request leaves on result: the frame class,
// its byte count (saturating at MAX_FRAME_BYTES, shown up to 2047), the IPv4
// addresses, the UDP ports and the payload offset and length.
// Throughput is one byte per cycle while the last byte of a frame is not held
// back by a stall; the counter and field capture take one byte each cycle. The
// last byte moves: input register, header snapshot, classification register.
// Reset clears the byte counter, the fields being captured and every valid flag;
// the first byte after reset starts a new frame.
// When result stalls, the classified frame holds in the result register and
// the next frame's header snapshot in its own stage; bytes of a following
// frame keep streaming in and only its last byte waits until a stage frees.
// ----------------------------------------------------------------------------
module ethernet_ipv4_rx_classifier_core
	import eipv4rx_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = DEFAULT_MAX_FRAME_BYTES
) (
	input  logic            clk,
	input  logic            arst_n,
	eipv4rx_byte_if.sink    rx,
	eipv4rx_class_if.source result
);

	localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

	logic          valid_s2;
	hdr_t          hdr_s2;
	logic [CW-1:0] len_s2;
	logic          cls_ready;

	eipv4rx_capture #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.down_ready(cls_ready),
		.valid_s2  (valid_s2),
		.hdr_s2    (hdr_s2),
		.len_s2    (len_s2)
	);

	eipv4rx_classify #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_classify (
		.clk     (clk),
		.arst_n  (arst_n),
		.valid_s2(valid_s2),
		.hdr_s2  (hdr_s2),
		.len_s2  (len_s2),
		.up_ready(cls_ready),
		.result  (result)
	);

endmodule
